/* sv/txc_pkg.sv */
package txc_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // First cell of the bottom row; a plain put that lands here scrolls
  localparam int SCROLL_START = (ROWS - 1) * COLUMNS;

  // Field widths of the item channels
  localparam int CMD_W   = 2;
  localparam int CODE_W  = 9;
  localparam int ATTR_W  = 8;
  localparam int DELTA_W = 12;
  localparam int ADDR_IN_W = 11;
  localparam int CUR_W   = 11;
  localparam int DATA_W  = 16;

  // Internal widths
  localparam int ADDR_W = $clog2(CELLS);       // memory index
  localparam int POS_W  = $clog2(CELLS + 1);   // position, may reach CELLS
  localparam int MOVE_W = ((POS_W + 1 > DELTA_W) ? POS_W + 1 : DELTA_W) + 1;

  // Character codes and cell values
  localparam logic [CODE_W-1:0] NEWLINE_CODE   = CODE_W'(10);
  localparam logic [CODE_W-1:0] BACKSPACE_CODE = CODE_W'(256);
  localparam logic [ATTR_W-1:0] PLAIN_ATTR     = 8'h07;
  localparam logic [DATA_W-1:0] BLANK_CELL     = 16'h0720;

  typedef enum logic [CMD_W-1:0] {
    CMD_PLAIN = 2'd0,
    CMD_COLOR = 2'd1,
    CMD_MOVE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // One write port and one read port of the screen memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

/* sv/txc_req_if.sv */
interface txc_req_if;
  import txc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [CODE_W-1:0]          char_code;
  logic [ATTR_W-1:0]          attribute;
  logic signed [DELTA_W-1:0]  delta;
  logic [ADDR_IN_W-1:0]       address;

  modport source (output valid, cmd, char_code, attribute, delta, address, input ready);
  modport sink (input valid, cmd, char_code, attribute, delta, address, output ready);
endinterface

/* sv/txc_rsp_if.sv */
interface txc_rsp_if;
  import txc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CUR_W-1:0]  cursor;
  logic [DATA_W-1:0] cell_data;

  modport source (output valid, cursor, cell_data, input ready);
  modport sink (input valid, cursor, cell_data, output ready);
endinterface

/* sv/txc_screen_ram.sv */
module txc_screen_ram (
  input  logic                           clk,
  input  txc_pkg::ram_req_t              req,
  output logic [txc_pkg::DATA_W-1:0]     rdata
);
  import txc_pkg::*;

  logic [DATA_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

/* sv/text_console_writer.sv */
// Text console writer: an 80x25 screen of 16-bit cells (attribute in
// bits 15..8, character in 7..0) held in one single-port-write,
// single-port-read memory, plus a cursor. Each request item yields
// exactly one response item with the cursor after the command and, for
// a read, the cell contents (zero otherwise). After reset the block
// sweeps all CELLS cells of the memory to zero, one cell per cycle,
// with req.ready low. The memory moves one cell per cycle; a newline
// steps down one row at a time, to the row below the cursor's, to find
// the next line start. A plain put that reaches the bottom row scrolls
// rows 1..23 up and clears the rest of row 23; a colored put past the
// last cell scrolls rows 1..24 up. One item is worked at a time. The
// response sits in an output register, so the next item can be taken
// while the last response waits for rsp.ready.
module text_console_writer (
  input logic         clk,
  input logic         rst,
  txc_req_if.sink     req,
  txc_rsp_if.source   rsp
);
  import txc_pkg::*;

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,  // post-reset clear sweep
    S_IDLE  = 9'b000000010,
    S_LINE  = 9'b000000100,  // search next line start
    S_CHECK = 9'b000001000,  // decide on scroll
    S_COPY  = 9'b000010000,  // move rows up, one cell a cycle
    S_CLEAR = 9'b000100000,  // zero rest of row above bottom
    S_FIN   = 9'b001000000,  // blank under cursor (plain only), commit cursor
    S_READ  = 9'b010000000,  // wait for read data
    S_EMIT  = 9'b100000000   // hand result to output register
  } state_t;

  state_t            state, state_next;
  logic [POS_W-1:0]  cur, cur_next;          // cursor register
  logic [POS_W-1:0]  pos, pos_next;          // working position
  logic [POS_W-1:0]  line, line_next;        // candidate line start
  logic [POS_W-1:0]  ctr, ctr_next;          // sweep / copy source
  logic [POS_W-1:0]  copy_end, copy_end_next;
  cmd_t              cmd_r, cmd_r_next;
  logic [DATA_W-1:0] res, res_next;
  logic              rd_valid, rd_valid_next;
  logic [ADDR_W-1:0] rd_dst, rd_dst_next;
  logic              out_valid, out_valid_next;
  logic [CUR_W-1:0]  out_cursor, out_cursor_next;
  logic [DATA_W-1:0] out_data, out_data_next;

  ram_req_t          ram;
  logic [DATA_W-1:0] rdata;

  logic signed [MOVE_W-1:0] move_sum;
  logic [POS_W-1:0]         move_pos;
  logic [POS_W-1:0]         dst_full;
  logic                     issue;
  cmd_t                     req_cmd;

  txc_screen_ram u_ram (
    .clk   (clk),
    .req   (ram),
    .rdata (rdata)
  );

  assign req_cmd = cmd_t'(req.cmd);

  // Clamped cursor move
  always_comb begin
    move_sum = $signed({{(MOVE_W-POS_W){1'b0}}, cur}) + MOVE_W'(req.delta);
    if (move_sum[MOVE_W-1]) begin
      move_pos = '0;
    end else if (move_sum > $signed(MOVE_W'(CELLS - 1))) begin
      move_pos = POS_W'(CELLS - 1);
    end else begin
      move_pos = move_sum[POS_W-1:0];
    end
  end

  assign dst_full = ctr - POS_W'(COLUMNS);
  assign issue    = (ctr != copy_end);

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.cursor    = out_cursor;
  assign rsp.cell_data = out_data;

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    pos_next        = pos;
    line_next       = line;
    ctr_next        = ctr;
    copy_end_next   = copy_end;
    cmd_r_next      = cmd_r;
    res_next        = res;
    rd_valid_next   = rd_valid;
    rd_dst_next     = rd_dst;
    out_valid_next  = out_valid && !rsp.ready;
    out_cursor_next = out_cursor;
    out_data_next   = out_data;
    ram             = '0;

    unique case (state)
      S_INIT: begin
        ram.we    = 1'b1;
        ram.waddr = ctr[ADDR_W-1:0];
        ram.wdata = '0;
        if (ctr == POS_W'(CELLS - 1)) begin
          ctr_next   = '0;
          state_next = S_IDLE;
        end else begin
          ctr_next = ctr + POS_W'(1);
        end
      end

      S_IDLE: begin
        if (req.valid) begin
          cmd_r_next = req_cmd;
          line_next  = POS_W'(COLUMNS);
          unique case (req_cmd)
            CMD_PLAIN: begin
              if (req.char_code == NEWLINE_CODE) begin
                state_next = S_LINE;
              end else if (req.char_code == BACKSPACE_CODE) begin
                pos_next   = (cur != '0) ? cur - POS_W'(1) : '0;
                state_next = S_CHECK;
              end else begin
                ram.we     = 1'b1;
                ram.waddr  = cur[ADDR_W-1:0];
                ram.wdata  = {PLAIN_ATTR, req.char_code[7:0]};
                pos_next   = cur + POS_W'(1);
                state_next = S_CHECK;
              end
            end
            CMD_COLOR: begin
              if (req.char_code == NEWLINE_CODE) begin
                state_next = S_LINE;
              end else begin
                ram.we     = 1'b1;
                ram.waddr  = cur[ADDR_W-1:0];
                ram.wdata  = {req.attribute, req.char_code[7:0]};
                pos_next   = cur + POS_W'(1);
                state_next = S_CHECK;
              end
            end
            CMD_MOVE: begin
              cur_next   = move_pos;
              res_next   = '0;
              state_next = S_EMIT;
            end
            CMD_READ: begin
              if (32'(req.address) < 32'(CELLS)) begin
                ram.re     = 1'b1;
                ram.raddr  = req.address[ADDR_W-1:0];
                state_next = S_READ;
              end else begin
                res_next   = '0;
                state_next = S_EMIT;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      // Step one row at a time until past the cursor
      S_LINE: begin
        if (line > cur) begin
          pos_next   = line;
          state_next = S_CHECK;
        end else begin
          line_next = line + POS_W'(COLUMNS);
        end
      end

      S_CHECK: begin
        ctr_next      = POS_W'(COLUMNS);
        rd_valid_next = 1'b0;
        if (cmd_r == CMD_PLAIN && pos >= POS_W'(SCROLL_START)) begin
          copy_end_next = POS_W'(SCROLL_START);
          pos_next      = pos - POS_W'(COLUMNS);
          state_next    = S_COPY;
        end else if (cmd_r == CMD_COLOR && pos >= POS_W'(CELLS)) begin
          copy_end_next = POS_W'(CELLS);
          pos_next      = pos - POS_W'(COLUMNS);
          state_next    = S_COPY;
        end else begin
          state_next = S_FIN;
        end
      end

      // Read source cell, write the previous one a row lower in address
      S_COPY: begin
        if (issue) begin
          ram.re   = 1'b1;
          ram.raddr = ctr[ADDR_W-1:0];
          ctr_next = ctr + POS_W'(1);
        end
        if (rd_valid) begin
          ram.we    = 1'b1;
          ram.waddr = rd_dst;
          ram.wdata = rdata;
        end
        rd_valid_next = issue;
        rd_dst_next   = dst_full[ADDR_W-1:0];
        if (!issue && !rd_valid) begin
          if (cmd_r == CMD_PLAIN) begin
            ctr_next   = pos;
            state_next = S_CLEAR;
          end else begin
            state_next = S_FIN;
          end
        end
      end

      S_CLEAR: begin
        if (ctr < POS_W'(SCROLL_START)) begin
          ram.we    = 1'b1;
          ram.waddr = ctr[ADDR_W-1:0];
          ram.wdata = '0;
          ctr_next  = ctr + POS_W'(1);
        end else begin
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (cmd_r == CMD_PLAIN) begin
          ram.we    = 1'b1;
          ram.waddr = pos[ADDR_W-1:0];
          ram.wdata = BLANK_CELL;
        end
        cur_next   = pos;
        res_next   = '0;
        state_next = S_EMIT;
      end

      S_READ: begin
        res_next   = rdata;
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_cursor_next = CUR_W'(cur);
          out_data_next   = res;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ctr       <= '0;
      cur       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ctr       <= ctr_next;
      cur       <= cur_next;
      rd_valid  <= rd_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    line       <= line_next;
    copy_end   <= copy_end_next;
    cmd_r      <= cmd_r_next;
    res        <= res_next;
    rd_dst     <= rd_dst_next;
    out_cursor <= out_cursor_next;
    out_data   <= out_data_next;
  end

endmodule
